[src/scp_pkg.sv]
// ============================================================================
// scp_pkg
// Shared types, character codes and helpers for the command line parser.
// ============================================================================
package scp_pkg;

  // Default buffer depth, register reset value and digit limit cap
  localparam int          LINE_DEPTH_DEF = 16;
  localparam logic [3:0]  MAX_DIGITS_RST = 4'd2;
  localparam logic [3:0]  MAX_LIMIT      = 4'd9;

  // Field widths
  localparam int NUM_W      = 30;
  localparam int NAME_IDX_W = 4;

  // Character codes
  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_EQ   = 8'h3D;
  localparam logic [7:0] CH_AT   = 8'h40;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_9    = 8'h39;
  localparam logic [7:0] CH_A    = 8'h41;
  localparam logic [7:0] CH_Z    = 8'h5A;

  // Result status codes
  typedef enum logic [1:0] {
    ST_WAIT     = 2'd0,
    ST_READY    = 2'd1,
    ST_BAD_CHAR = 2'd2,
    ST_TOO_LONG = 2'd3
  } status_t;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_NAME_RD,
    S_NAME_OUT,
    S_BAD_OUT
  } state_t;

  // Controls for the decimal accumulator
  typedef struct packed {
    logic       clear;
    logic       step;
    logic [3:0] digit;
  } acc_ctrl_t;

  function automatic logic is_digit(input logic [7:0] b);
    is_digit = (b >= CH_0) && (b <= CH_9);
  endfunction

  function automatic logic byte_allowed(input logic [7:0] b);
    byte_allowed = (b == CH_AT) || (b == CH_EQ) || (b == CH_NUL) ||
                   (b == CH_LF) || (b == CH_CR) || is_digit(b) ||
                   ((b >= CH_A) && (b <= CH_Z));
  endfunction

endpackage

[src/serial_command_line_parser.sv]
// ============================================================================
// serial_command_line_parser
// Collects "@NAME=NN" command lines byte by byte in a line RAM and, on LF,
// scans the line to check the frame, parse the value and emit the name.
// ============================================================================
// A stored, ignored or rejected byte yields its beat in the next cycle.
// An LF scans up to the n buffered bytes through the RAM read port, then
// emits one beat per name character (RAM read state, then load state), or
// one beat for a bad frame. Takes a byte per cycle while idle, output free.
// Reset clears the fill count, the controller and max_digits (to 2); the
// line RAM is not cleared, only entries written in the current line are read.
module serial_command_line_parser
  import scp_pkg::*;
#(
  parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_write,
  input  logic [3:0]            cfg_data,
  // byte input
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            rx_byte,
  // result output
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            status,
  output logic                  frame_ok,
  output logic                  value_ok,
  output logic [NUM_W-1:0]      number_value,
  output logic [7:0]            name_char,
  output logic [NAME_IDX_W-1:0] name_index,
  output logic                  last
);

  localparam int AW = $clog2(LINE_DEPTH);
  localparam int CW = $clog2(LINE_DEPTH + 1);
  localparam int XW = CW + NAME_IDX_W;

  state_t           state;
  state_t           state_next;
  logic [3:0]       max_digits;
  logic [CW-1:0]    fill_count;
  logic [CW-1:0]    scan_n;
  logic [CW-1:0]    rd_idx;
  logic [CW-1:0]    data_idx;
  logic             data_vld;
  logic             eq_found;
  logic [CW-1:0]    eq_pos;
  logic             vok;
  logic [3:0]       digits;
  logic [CW-1:0]    nm_idx;

  logic             out_free;
  logic             in_beat;
  logic             lf_beat;
  logic             buf_full;
  logic             out_load;
  status_t          status_next;
  logic             frame_ok_next;
  logic             value_ok_next;
  logic [NUM_W-1:0] number_next;
  logic [7:0]       name_char_next;
  logic [NAME_IDX_W-1:0] name_index_next;
  logic             last_next;

  logic             ram_we;
  logic [AW-1:0]    ram_raddr;
  logic [7:0]       ram_rdata;
  acc_ctrl_t        acc_ctrl;
  logic [NUM_W-1:0] acc;

  logic [3:0]       limit;
  logic             scan_bad;
  logic             scan_eq_hit;
  logic             scan_val_end;
  logic             scan_last_byte;
  logic             scan_end;
  logic             scan_good;
  logic             vok_clr;
  logic             name_last;
  logic [XW-1:0]    nm_off;

  // Handshake qualifiers
  assign out_free = !out_valid || !out_stall;
  assign in_beat  = in_valid && !in_stall;
  assign lf_beat  = in_beat && (rx_byte == CH_LF);
  assign buf_full = (fill_count >= CW'(LINE_DEPTH));
  assign limit    = (max_digits > MAX_LIMIT) ? MAX_LIMIT : max_digits;
  assign name_last = ((nm_idx + CW'(1)) == eq_pos);
  assign nm_off    = XW'(nm_idx) - XW'(1);

  // Line RAM
  scp_ram #(
    .WIDTH(8),
    .DEPTH(LINE_DEPTH)
  ) u_line_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(fill_count[AW-1:0]),
    .wdata(rx_byte),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Value accumulator
  scp_value u_value (
    .clk (clk),
    .ctrl(acc_ctrl),
    .acc (acc)
  );

  // Decode one scanned byte: frame checks and value digits
  always_comb begin
    scan_bad       = 1'b0;
    scan_eq_hit    = 1'b0;
    scan_val_end   = 1'b0;
    scan_last_byte = 1'b0;
    vok_clr        = 1'b0;
    acc_ctrl.clear = lf_beat;
    acc_ctrl.step  = 1'b0;
    acc_ctrl.digit = 4'(ram_rdata - CH_0);
    if (state == S_SCAN && data_vld) begin
      scan_last_byte = (data_idx == (scan_n - CW'(1)));
      if (data_idx == '0) begin
        if (ram_rdata != CH_AT) begin
          scan_bad = 1'b1;
        end
      end else if (!eq_found) begin
        if (ram_rdata == CH_NUL) begin
          scan_bad = 1'b1;
        end else if (ram_rdata == CH_EQ) begin
          if (data_idx == CW'(1)) begin
            scan_bad = 1'b1;
          end else begin
            scan_eq_hit = 1'b1;
          end
        end
      end else begin
        if (ram_rdata == CH_NUL) begin
          scan_val_end = 1'b1;
        end else if (vok) begin
          if (!is_digit(ram_rdata) || (digits >= limit)) begin
            vok_clr = 1'b1;
          end else begin
            acc_ctrl.step = 1'b1;
          end
        end
      end
    end
    scan_end  = scan_bad || scan_val_end || scan_last_byte;
    scan_good = !scan_bad && (eq_found || scan_eq_hit);
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (lf_beat) begin
          state_next = (fill_count == '0) ? S_BAD_OUT : S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_end) begin
          state_next = scan_good ? S_NAME_RD : S_BAD_OUT;
        end
      end
      S_NAME_RD: begin
        state_next = S_NAME_OUT;
      end
      S_NAME_OUT: begin
        if (out_free) begin
          state_next = name_last ? S_IDLE : S_NAME_RD;
        end
      end
      S_BAD_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Controller outputs: input stall, RAM access, result beat
  always_comb begin
    in_stall        = !(state == S_IDLE && out_free);
    ram_raddr       = (state == S_SCAN) ? rd_idx[AW-1:0] : nm_idx[AW-1:0];
    ram_we          = 1'b0;
    out_load        = 1'b0;
    status_next     = ST_WAIT;
    frame_ok_next   = 1'b0;
    value_ok_next   = 1'b0;
    number_next     = '0;
    name_char_next  = '0;
    name_index_next = '0;
    last_next       = 1'b1;
    unique case (state)
      S_IDLE: begin
        if (in_beat) begin
          if (!byte_allowed(rx_byte)) begin
            out_load    = 1'b1;
            status_next = ST_BAD_CHAR;
          end else if (rx_byte == CH_CR) begin
            out_load = 1'b1;
          end else if (rx_byte != CH_LF) begin
            out_load = 1'b1;
            if (buf_full) begin
              status_next = ST_TOO_LONG;
            end else begin
              ram_we = 1'b1;
            end
          end
        end
      end
      S_NAME_OUT: begin
        if (out_free) begin
          out_load        = 1'b1;
          status_next     = ST_READY;
          frame_ok_next   = 1'b1;
          value_ok_next   = vok;
          number_next     = vok ? acc : '0;
          name_char_next  = ram_rdata;
          name_index_next = nm_off[NAME_IDX_W-1:0];
          last_next       = name_last;
        end
      end
      S_BAD_OUT: begin
        if (out_free) begin
          out_load    = 1'b1;
          status_next = ST_READY;
        end
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      max_digits <= MAX_DIGITS_RST;
      fill_count <= '0;
      out_valid  <= 1'b0;
      data_vld   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        max_digits <= cfg_data;
      end
      // advance on a stored byte, empty on a line end
      if (lf_beat) begin
        fill_count <= '0;
      end else if (ram_we) begin
        fill_count <= fill_count + CW'(1);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      data_vld <= (state == S_SCAN) && !scan_end && (rd_idx < scan_n);
    end
  end

  // Scan and name walk registers
  always_ff @(posedge clk) begin
    if (lf_beat) begin
      scan_n   <= fill_count;
      rd_idx   <= '0;
      eq_found <= 1'b0;
      vok      <= 1'b1;
      digits   <= '0;
    end else if (state == S_SCAN) begin
      if (rd_idx < scan_n) begin
        rd_idx <= rd_idx + CW'(1);
      end
      if (scan_eq_hit) begin
        eq_found <= 1'b1;
        eq_pos   <= data_idx;
      end
      if (vok_clr) begin
        vok <= 1'b0;
      end
      if (acc_ctrl.step) begin
        digits <= digits + 4'd1;
      end
    end
    data_idx <= rd_idx;
    // start the name walk after the separator-checked scan
    if (state == S_SCAN && scan_end) begin
      nm_idx <= CW'(1);
    end else if (state == S_NAME_OUT && out_load) begin
      nm_idx <= nm_idx + CW'(1);
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      status       <= status_next;
      frame_ok     <= frame_ok_next;
      value_ok     <= value_ok_next;
      number_value <= number_next;
      name_char    <= name_char_next;
      name_index   <= name_index_next;
      last         <= last_next;
    end
  end

  // Fill count never passes the buffer depth
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CW'(LINE_DEPTH))
    else $error("fill count beyond line depth");

  // Name walk stays between the leading marker and the separator
  a_name_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_NAME_RD) |-> (eq_found && nm_idx >= CW'(1) && nm_idx < eq_pos))
    else $error("name walk out of range");

  // A line end empties the buffer and leaves idle
  a_lf_clears: assert property (@(posedge clk) disable iff (rst)
    lf_beat |=> (fill_count == '0 && state != S_IDLE))
    else $error("line end did not start the scan");

endmodule

[src/scp_ram.sv]
// ============================================================================
// scp_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ============================================================================
module scp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/scp_value.sv]
// ============================================================================
// scp_value
// Decimal value accumulator: one digit per step, times ten by shift and add.
// ============================================================================
module scp_value
  import scp_pkg::*;
(
  input  logic             clk,
  input  acc_ctrl_t        ctrl,
  output logic [NUM_W-1:0] acc
);

  logic [NUM_W-1:0] acc_next;

  // Clear on a new line, fold in one digit per step
  always_comb begin
    acc_next = acc;
    if (ctrl.clear) begin
      acc_next = '0;
    end else if (ctrl.step) begin
      acc_next = (acc << 3) + (acc << 1) + NUM_W'(ctrl.digit);
    end
  end

  always_ff @(posedge clk) begin
    acc <= acc_next;
  end

endmodule
